// File: rtl/core/hcns_pkg.sv
// Shared types, constants and heading lookup functions for the heading corridor
// nearest-candidate selector. Depends on nothing; every other file uses it.
package hcns_pkg;

   localparam int ID_W      = 32;
   localparam int LON_W     = 28;
   localparam int LAT_W     = 27;
   localparam int CLAT_W    = 26;
   localparam int HEAD_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_VEHICLE_LON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VEHICLE_LAT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_DEG = 2'd2;

   localparam logic [LON_W-1:0]  DEFAULT_LON  = 28'd126700000;
   localparam logic [LAT_W-1:0]  DEFAULT_LAT  = 27'd37400000;
   localparam logic [HEAD_W-1:0] DEFAULT_HEAD = 9'd0;

   // Path walk
   localparam int PATH_POINTS = 201;
   localparam int STEP_W      = 8;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PATH_POINTS - 1);
   localparam int BOX_HALF    = 200;
   localparam int POS_W       = 30;
   localparam int UNIT_W      = 5;
   localparam logic signed [POS_W-1:0] BOX_HI = POS_W'(BOX_HALF);
   localparam logic signed [POS_W-1:0] BOX_LO = -BOX_HI;

   // Distance squares
   localparam int OP_W   = 28;
   localparam int PROD_W = 2 * OP_W;
   localparam int DIST_W = PROD_W + 1;

   // Upper angle of each rounded cosine value, from 10 down to 1
   localparam logic [6:0] COS_EDGE [10] = '{
      7'd18, 7'd31, 7'd41, 7'd49, 7'd56, 7'd63, 7'd69, 7'd75, 7'd81, 7'd87
   };

   typedef struct packed {
      logic [ID_W-1:0]   cand_id;
      logic [LON_W-1:0]  cand_lon;
      logic [CLAT_W-1:0] cand_lat;
      logic              first_of_query;
   } req_word_type;

   typedef struct packed {
      logic              accepted;
      logic              found_any;
      logic [ID_W-1:0]   best_id;
      logic [LON_W-1:0]  best_lon;
      logic [LAT_W-1:0]  best_lat;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SEL,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   // round(10*cos(a)) for a in 0..90 degrees
   function automatic logic signed [UNIT_W-1:0] quarter_cos(input logic [6:0] a);
      logic signed [UNIT_W-1:0] r;
      logic                     hit;
      r   = '0;
      hit = 1'b0;
      for (int k = 0; k < 10; k++) begin
         if (!hit && (a <= COS_EDGE[k])) begin
            r   = UNIT_W'(10 - k);
            hit = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [HEAD_W-1:0] wrap_heading(input logic [HEAD_W-1:0] h);
      return (h >= 9'd360) ? h - 9'd360 : h;
   endfunction

   // round(10*cos(h)) for any 9-bit heading, taken modulo 360
   function automatic logic signed [UNIT_W-1:0] unit_cos(input logic [HEAD_W-1:0] h);
      logic [HEAD_W-1:0] hm;
      hm = wrap_heading(h);
      if (hm <= 9'd90) begin
         return quarter_cos(hm[6:0]);
      end else if (hm <= 9'd180) begin
         return -quarter_cos(7'(9'd180 - hm));
      end else if (hm <= 9'd270) begin
         return -quarter_cos(7'(hm - 9'd180));
      end else begin
         return quarter_cos(7'(9'd360 - hm));
      end
   endfunction

   // round(10*sin(h)), taken as the cosine of h - 90
   function automatic logic signed [UNIT_W-1:0] unit_sin(input logic [HEAD_W-1:0] h);
      logic [HEAD_W-1:0] hm;
      logic [HEAD_W-1:0] hs;
      hm = wrap_heading(h);
      hs = (hm >= 9'd90) ? hm - 9'd90 : hm + 9'd270;
      return unit_cos(hs);
   endfunction

endpackage

// File: rtl/core/hcns_chan_if.sv
// Valid/ready channel interfaces for the candidate words and the result words.
// Depends on hcns_pkg for the payload types.
interface hcns_req_if;
   logic                      valid;
   logic                      ready;
   hcns_pkg::req_word_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface hcns_rsp_if;
   logic                      valid;
   logic                      ready;
   hcns_pkg::rsp_word_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/heading_corridor_nearest_select_top.sv
// Top level of the heading corridor nearest-candidate selector.
// Depends on hcns_pkg and the channel interfaces in hcns_chan_if.sv.
//
// Use: the csr_ port sets the vehicle longitude, latitude and heading (index 0, 1, 2),
// written only while the block is idle. Candidate words arrive on req_ch; each one
// yields exactly one result word on rsp_ch carrying whether it was taken and the
// best candidate of the current query. A word with first_of_query set restores the
// default point before it is judged.
// One candidate is handled at a time. An adder pair steps along the heading, one
// path point a cycle, until the candidate box is hit or all 201 points are seen;
// then one shared 28x28 multiplier forms the four distance squares in turn. The
// next word is taken only after the result word of the last one has been written.
// The result sits in an output register; if the receiver stalls, the block still
// takes the next word and holds its finished result until the register frees.
// Reset restores the default vehicle position, heading 0 and the default point.
module heading_corridor_nearest_select_top (
   input  logic                                clock,
   input  logic                                reset,
   hcns_req_if.sink                            req_ch,
   hcns_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [hcns_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hcns_pkg::CSR_W-1:0]          csr_wdata
);

   hcns_pkg::state_type                    state_ff, state_in;
   logic [hcns_pkg::LON_W-1:0]             vlon_ff, vlon_in;
   logic [hcns_pkg::LAT_W-1:0]             vlat_ff, vlat_in;
   logic [hcns_pkg::HEAD_W-1:0]            head_ff, head_in;

   hcns_pkg::req_word_type                 cand_ff, cand_in;
   logic [hcns_pkg::STEP_W-1:0]            step_ff, step_in;
   logic signed [hcns_pkg::POS_W-1:0]      px_ff, px_in;
   logic signed [hcns_pkg::POS_W-1:0]      py_ff, py_in;
   logic signed [hcns_pkg::UNIT_W-1:0]     ux_ff, ux_in;
   logic signed [hcns_pkg::UNIT_W-1:0]     uy_ff, uy_in;
   logic                                   hit_ff, hit_in;

   logic [1:0]                             idx_ff, idx_in;
   logic [hcns_pkg::OP_W-1:0]              op_ff, op_in;
   logic [hcns_pkg::PROD_W-1:0]            prod_ff, prod_in;
   logic [hcns_pkg::DIST_W-1:0]            distc_ff, distc_in;
   logic [hcns_pkg::DIST_W-1:0]            distk_ff, distk_in;

   logic [hcns_pkg::LON_W-1:0]             kept_lon_ff, kept_lon_in;
   logic [hcns_pkg::LAT_W-1:0]             kept_lat_ff, kept_lat_in;
   logic [hcns_pkg::ID_W-1:0]              kept_id_ff, kept_id_in;
   logic                                   kept_found_ff, kept_found_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   hcns_pkg::rsp_word_type                 rsp_word_ff, rsp_word_in;

   logic signed [hcns_pkg::POS_W-1:0]      dx, dy;
   logic                                   in_box;
   logic [hcns_pkg::OP_W-1:0]              op_a, op_b;
   logic                                   nearer;
   logic                                   take;
   logic                                   out_free;

   assign req_ch.ready = (state_ff == hcns_pkg::ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_word_ff;

   // Offsets of the current path point from the candidate
   assign dx = px_ff - hcns_pkg::POS_W'(cand_ff.cand_lon);
   assign dy = py_ff - hcns_pkg::POS_W'(cand_ff.cand_lat);
   assign in_box = (dx > hcns_pkg::BOX_LO) && (dx < hcns_pkg::BOX_HI) &&
                   (dy > hcns_pkg::BOX_LO) && (dy < hcns_pkg::BOX_HI);

   // Operand pair for the shared squaring unit: candidate first, then kept best
   always_comb begin
      unique case (idx_ff)
         2'd0: begin
            op_a = cand_ff.cand_lon;
            op_b = vlon_ff;
         end
         2'd1: begin
            op_a = hcns_pkg::OP_W'(cand_ff.cand_lat);
            op_b = hcns_pkg::OP_W'(vlat_ff);
         end
         2'd2: begin
            op_a = kept_lon_ff;
            op_b = vlon_ff;
         end
         default: begin
            op_a = hcns_pkg::OP_W'(kept_lat_ff);
            op_b = hcns_pkg::OP_W'(vlat_ff);
         end
      endcase
   end

   assign nearer   = (distc_ff < distk_ff);
   assign take     = hit_ff && nearer;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      vlon_in       = vlon_ff;
      vlat_in       = vlat_ff;
      head_in       = head_ff;
      cand_in       = cand_ff;
      step_in       = step_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      hit_in        = hit_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      prod_in       = prod_ff;
      distc_in      = distc_ff;
      distk_in      = distk_ff;
      kept_lon_in   = kept_lon_ff;
      kept_lat_in   = kept_lat_ff;
      kept_id_in    = kept_id_ff;
      kept_found_in = kept_found_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      if (csr_we) begin
         unique case (csr_index)
            hcns_pkg::CSR_VEHICLE_LON: vlon_in = csr_wdata;
            hcns_pkg::CSR_VEHICLE_LAT: vlat_in = hcns_pkg::LAT_W'(csr_wdata);
            hcns_pkg::CSR_HEADING_DEG: head_in = hcns_pkg::HEAD_W'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         hcns_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               cand_in  = req_ch.data;
               step_in  = '0;
               px_in    = hcns_pkg::POS_W'(vlon_ff);
               py_in    = hcns_pkg::POS_W'(vlat_ff);
               ux_in    = hcns_pkg::unit_cos(head_ff);
               uy_in    = hcns_pkg::unit_sin(head_ff);
               hit_in   = 1'b0;
               idx_in   = 2'd0;
               distc_in = '0;
               distk_in = '0;
               if (req_ch.data.first_of_query) begin
                  kept_lon_in   = hcns_pkg::DEFAULT_LON;
                  kept_lat_in   = hcns_pkg::DEFAULT_LAT;
                  kept_id_in    = '0;
                  kept_found_in = 1'b0;
               end
               state_in = hcns_pkg::ST_WALK;
            end
         end
         hcns_pkg::ST_WALK: begin
            if (in_box) begin
               hit_in   = 1'b1;
               state_in = hcns_pkg::ST_SEL;
            end else if (step_ff == hcns_pkg::LAST_STEP) begin
               state_in = hcns_pkg::ST_SEL;
            end else begin
               step_in = step_ff + 1'b1;
               px_in   = px_ff + hcns_pkg::POS_W'(ux_ff);
               py_in   = py_ff + hcns_pkg::POS_W'(uy_ff);
            end
         end
         hcns_pkg::ST_SEL: begin
            op_in    = (op_a >= op_b) ? op_a - op_b : op_b - op_a;
            state_in = hcns_pkg::ST_MUL;
         end
         hcns_pkg::ST_MUL: begin
            prod_in  = hcns_pkg::PROD_W'(op_ff) * hcns_pkg::PROD_W'(op_ff);
            state_in = hcns_pkg::ST_ACC;
         end
         hcns_pkg::ST_ACC: begin
            if (!idx_ff[1]) begin
               distc_in = distc_ff + hcns_pkg::DIST_W'(prod_ff);
            end else begin
               distk_in = distk_ff + hcns_pkg::DIST_W'(prod_ff);
            end
            if (idx_ff == 2'd3) begin
               state_in = hcns_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = hcns_pkg::ST_SEL;
            end
         end
         hcns_pkg::ST_DONE: begin
            // The kept best is committed together with the result word.
            if (out_free) begin
               rsp_word_in.accepted  = take;
               rsp_word_in.found_any = take ? 1'b1 : kept_found_ff;
               rsp_word_in.best_id   = take ? cand_ff.cand_id : kept_id_ff;
               rsp_word_in.best_lon  = take ? cand_ff.cand_lon : kept_lon_ff;
               rsp_word_in.best_lat  = take ? hcns_pkg::LAT_W'(cand_ff.cand_lat)
                                            : kept_lat_ff;
               rsp_valid_in = 1'b1;
               if (take) begin
                  kept_lon_in   = cand_ff.cand_lon;
                  kept_lat_in   = hcns_pkg::LAT_W'(cand_ff.cand_lat);
                  kept_id_in    = cand_ff.cand_id;
                  kept_found_in = 1'b1;
               end
               state_in = hcns_pkg::ST_IDLE;
            end
         end
         default: state_in = hcns_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hcns_pkg::ST_IDLE;
         vlon_ff       <= hcns_pkg::DEFAULT_LON;
         vlat_ff       <= hcns_pkg::DEFAULT_LAT;
         head_ff       <= hcns_pkg::DEFAULT_HEAD;
         kept_lon_ff   <= hcns_pkg::DEFAULT_LON;
         kept_lat_ff   <= hcns_pkg::DEFAULT_LAT;
         kept_id_ff    <= '0;
         kept_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
         idx_ff        <= '0;
         hit_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vlon_ff       <= vlon_in;
         vlat_ff       <= vlat_in;
         head_ff       <= head_in;
         kept_lon_ff   <= kept_lon_in;
         kept_lat_ff   <= kept_lat_in;
         kept_id_ff    <= kept_id_in;
         kept_found_ff <= kept_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
         idx_ff        <= idx_in;
         hit_ff        <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      op_ff       <= op_in;
      prod_ff     <= prod_in;
      distc_ff    <= distc_in;
      distk_ff    <= distk_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule
